>>> src/fcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants for the FIFO with content statistics.
// ----------------------------------------------------------------------------
package fcs_pkg;

    // fixed field widths
    localparam int VALUE_W  = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int SUMOUT_W = 20;
    localparam int MEAN_W   = 24;
    localparam int FRAC_W   = 8;

    // saturation limits of the reported sum
    localparam int SUMOUT_MAX = 524287;
    localparam int SUMOUT_MIN = -524288;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } fcs_state_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } fcs_div_stat_t;

endpackage

>>> src/fifo_with_content_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_content_statistics
// Bounded FIFO of signed 16-bit values reporting count, sum, min, max and mean.
// ----------------------------------------------------------------------------
// Sequence: a pop first reads the head entry, then the RAM walk reads the N entries
// left after the operation, one read a cycle, and the bit-serial mean divider works
// out Q = 25 + clog2(DEPTH) quotient bits. An operation leaving the queue empty
// skips the divider. A new item is taken only once the last result is loaded into
// the output register; a result held by the receiver holds the input off.
// Reset: synchronous active-low aresetn empties the queue; RAM contents stay.
// ----------------------------------------------------------------------------
module fifo_with_content_statistics
    import fcs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input channel
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,   // [15:0] value
    input  logic [1:0]    s_tuser,   // [1:0] op
    // result channel
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // [15:0] removed_value, [20:16] entry_count,
                                     // [40:21] sum_of_entries, [56:41] smallest,
                                     // [72:57] largest, [96:73] mean_q8, rest zero
    output logic [1:0]    m_tuser    // [1:0] status
);

    // derived widths
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = VALUE_W + 1 + $clog2(DEPTH);   // exact running total
    localparam int DIV_W = SUM_W + FRAC_W;                // |sum| * 256

    // sequencer and queue state
    fcs_state_t state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // item registers
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  removed_reg, removed_next;

    // walk and statistics accumulator
    logic [PTR_W-1:0]          walk_ptr_reg, walk_ptr_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic                      rvalid_reg, rvalid_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [VALUE_W-1:0] lo_reg, lo_next;
    logic signed [VALUE_W-1:0] hi_reg, hi_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [103:0]        m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    // control
    logic s_fire;
    logic ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]   ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    logic div_start;
    logic load_out;
    fcs_div_stat_t div_stat;
    logic [DIV_W-1:0] div_quot;

    // datapath helpers
    logic signed [VALUE_W-1:0] rd_entry;
    logic [SUM_W-1:0]          sum_abs;
    logic [DIV_W-1:0]          mean_mag;
    logic signed [31:0]        sum_wide;
    logic signed [31:0]        sum_sat;
    logic [MEAN_W-1:0]         mean_out;
    logic [COUNT_W-1:0]        count_out;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign s_fire   = s_tvalid && s_tready;
    assign rd_entry = $signed(ram_rd_data);

    fcs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fcs_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_abs, {FRAC_W{1'b0}}}),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == OP_POP && count_reg != '0) ? S_POP : S_WALK;
                end
            end
            S_POP: begin
                state_next = S_WALK;
            end
            S_WALK: begin
                if (issue_reg == count_reg && !rvalid_reg) begin
                    state_next = (count_reg != '0) ? S_DIV_START : S_DONE;
                end
            end
            S_DIV_START: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        div_start   = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // hold off transfers while in reset
                s_tready  = aresetn;
                // write on push, fetch the head in case this is a pop
                ram_wr_en = s_fire && s_tuser == OP_PUSH && count_reg != CNT_W'(DEPTH);
                ram_rd_en = 1'b1;
            end
            S_WALK: begin
                ram_rd_en   = issue_reg != count_reg;
                ram_rd_addr = walk_ptr_reg;
            end
            S_DIV_START: begin
                div_start = 1'b1;
            end
            S_DONE: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result formatting
    always_comb begin
        sum_abs   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mean_mag  = sum_reg[SUM_W-1] ? DIV_W'(-div_quot) : div_quot;
        mean_out  = (count_reg != '0) ? mean_mag[MEAN_W-1:0] : '0;
        sum_wide  = 32'(sum_reg);
        sum_sat   = sum_wide;
        if (sum_wide > SUMOUT_MAX) begin
            sum_sat = SUMOUT_MAX;
        end else if (sum_wide < SUMOUT_MIN) begin
            sum_sat = SUMOUT_MIN;
        end
        count_out = COUNT_W'(count_reg);
    end

    // datapath
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        walk_ptr_next = walk_ptr_reg;
        issue_next    = issue_reg;
        rvalid_next   = 1'b0;
        sum_next      = sum_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next       = s_tuser;
                    status_next   = STATUS_OK;
                    removed_next  = '0;
                    walk_ptr_next = head_reg;
                    case (s_tuser)
                        OP_PUSH: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                tail_next  = ptr_inc(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end
                        end
                        OP_CLEAR: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                head_next     = '0;
                                tail_next     = '0;
                                count_next    = '0;
                                walk_ptr_next = '0;
                            end
                        end
                        default: begin
                            status_next = STATUS_OK;
                        end
                    endcase
                    issue_next = '0;
                    sum_next   = '0;
                    lo_next    = 16'sh7fff;
                    hi_next    = -16'sh8000;
                end
            end
            S_POP: begin
                // head word arrives from the RAM now
                removed_next  = ram_rd_data;
                head_next     = ptr_inc(head_reg);
                count_next    = count_reg - 1'b1;
                walk_ptr_next = ptr_inc(head_reg);
            end
            S_WALK: begin
                if (issue_reg != count_reg) begin
                    walk_ptr_next = ptr_inc(walk_ptr_reg);
                    issue_next    = issue_reg + 1'b1;
                    rvalid_next   = 1'b1;
                end
                if (rvalid_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_entry);
                    if (rd_entry < lo_reg) begin
                        lo_next = rd_entry;
                    end
                    if (rd_entry > hi_reg) begin
                        hi_next = rd_entry;
                    end
                end
            end
            S_DONE: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = '0;
                    m_tdata_next[15:0]  = removed_reg;
                    m_tdata_next[20:16] = count_out;
                    m_tdata_next[40:21] = SUMOUT_W'(sum_sat);
                    m_tdata_next[56:41] = (count_reg != '0) ? lo_reg : '0;
                    m_tdata_next[72:57] = (count_reg != '0) ? hi_reg : '0;
                    m_tdata_next[96:73] = mean_out;
                end
            end
            default: begin
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            issue_reg    <= '0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rvalid_reg   <= rvalid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg       <= op_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
        walk_ptr_reg <= walk_ptr_next;
        sum_reg      <= sum_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // occupancy stays within the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    // no new transfer is taken while the divider works
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_tready)
        else $error("input ready during division");

    // an accepted push to a queue with room adds exactly one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == OP_PUSH && count_reg != CNT_W'(DEPTH))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the queue");

    // a push leaving the queue full never reports empty status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && op_reg == OP_PUSH && count_reg == CNT_W'(DEPTH))
        |-> status_reg != STATUS_EMPTY)
        else $error("push reported empty status");

    // the read pipeline is only active during the walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> $past(state_reg) == S_WALK)
        else $error("entry read outside the walk");

endmodule

>>> src/fcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/fcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcs_div
    import fcs_pkg::*;
#(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output fcs_div_stat_t         stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int ITER_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // subtract when the shifted remainder covers the divisor
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO with content statistics. It keeps its own
// copy of the queue, predicts status, removed value, count, total, smallest,
// largest and Q.8 mean for every accepted operation, and compares each result
// transfer field by field. It covers directed corner cases and random
// push/pop/clear traffic, with random idling on both sides and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb
    import fcs_pkg::*;
();

    localparam int DEPTH = 16;
    // op code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one expected result transfer
    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  removed;
        logic [COUNT_W-1:0]         count;
        logic signed [SUMOUT_W-1:0] total;
        logic signed [VALUE_W-1:0]  lo;
        logic signed [VALUE_W-1:0]  hi;
        logic signed [MEAN_W-1:0]   mean;
    } fifo_stats_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [15:0]   s_tdata;    // [15:0] value
    logic [1:0]    s_tuser;    // [1:0] op
    logic          m_tvalid;
    logic          m_tready;
    logic [103:0]  m_tdata;    // [15:0] removed_value, [20:16] entry_count,
                               // [40:21] sum_of_entries, [56:41] smallest,
                               // [72:57] largest, [96:73] mean_q8, rest zero
    logic [1:0]    m_tuser;    // [1:0] status

    // mirror of the queue contents, head at index 0
    logic signed [VALUE_W-1:0] model_fifo[$];
    // statistics still owed by the block, oldest first
    fifo_stats_t               pending_stats[$];

    int  mismatch_count = 0;
    int  result_index   = 0;
    bit  calm           = 1'b0;  // set to suppress random idling on both sides
    int  rx_hold_req    = 0;     // cycles the receiver is asked to hold off

    fifo_with_content_statistics #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one operation to the mirror and work out the result.
    // ------------------------------------------------------------------------
    function automatic fifo_stats_t predict_stats(logic [OP_W-1:0] op,
                                                  logic signed [VALUE_W-1:0] value);
        fifo_stats_t r;
        int          total;
        int          mean;
        int          n;
        r        = '0;
        r.status = STATUS_OK;
        case (op)
            OP_PUSH: begin
                if (model_fifo.size() >= DEPTH) r.status = STATUS_FULL;
                else model_fifo.push_back(value);
            end
            OP_POP: begin
                if (model_fifo.size() == 0) r.status = STATUS_EMPTY;
                else r.removed = model_fifo.pop_front();
            end
            OP_CLEAR: begin
                if (model_fifo.size() == 0) r.status = STATUS_EMPTY;
                else model_fifo.delete();
            end
            default: ;  // unused code: queue left alone, statistics still reported
        endcase

        n       = model_fifo.size();
        r.count = n[COUNT_W-1:0];
        total   = 0;
        mean    = 0;
        if (n > 0) begin
            r.lo = model_fifo[0];
            r.hi = model_fifo[0];
            foreach (model_fifo[i]) begin
                total += int'(model_fifo[i]);
                if (model_fifo[i] < r.lo) r.lo = model_fifo[i];
                if (model_fifo[i] > r.hi) r.hi = model_fifo[i];
            end
            // SV integer division truncates toward zero, as the block must
            mean = (total * (1 << FRAC_W)) / n;
        end
        // the reported total saturates; the mean uses the exact total
        if (total > SUMOUT_MAX) total = SUMOUT_MAX;
        if (total < SUMOUT_MIN) total = SUMOUT_MIN;
        r.total = total[SUMOUT_W-1:0];
        r.mean  = mean[MEAN_W-1:0];
        return r;
    endfunction

    // print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", result_index, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Result checker: compare each result transfer with the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic check_result(input logic [103:0] data, input logic [1:0] status);
        fifo_stats_t want;
        if (pending_stats.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
        end else begin
            want = pending_stats.pop_front();
            check_field("status",         32'(status),      32'(want.status));
            check_field("removed_value",  32'(data[15:0]),  32'($unsigned(want.removed)));
            check_field("entry_count",    32'(data[20:16]), 32'(want.count));
            check_field("sum_of_entries", 32'(data[40:21]), 32'($unsigned(want.total)));
            check_field("smallest",       32'(data[56:41]), 32'($unsigned(want.lo)));
            check_field("largest",        32'(data[72:57]), 32'($unsigned(want.hi)));
            check_field("mean_q8",        32'(data[96:73]), 32'($unsigned(want.mean)));
            check_field("padding",        32'(data[103:97]), 32'd0);
        end
        result_index++;
    endtask

    // sample at the rising edge, where the transfer happens
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata, m_tuser);
    end

    // ------------------------------------------------------------------------
    // Receiver: drive m_tready at the falling edge. Idle at random with a probability
    // of about ten percent, unless calm; honour a hold-off request by counting it down.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = calm || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one operation, hold it until the transfer, then record the
    // expected statistics. tvalid is left high so back-to-back items need no
    // gap; idle cycles are inserted at random beforehand.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [OP_W-1:0] op,
                           input logic signed [VALUE_W-1:0] value);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
        pending_stats.push_back(predict_stats(op, value));
    endtask

    // random value with extra weight on the extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // pop, clear and the unused code on an empty queue
    task automatic test_empty_queue();
        send_op(OP_POP,    16'sd1234);
        send_op(OP_CLEAR,  -16'sd1);
        send_op(OP_UNUSED, 16'sd77);
    endtask

    // fill to the brim with extremes, refuse one more push, then drain a bit
    task automatic test_fill_and_drain();
        logic signed [VALUE_W-1:0] fill_vals[DEPTH];
        fill_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
                      16'sd21845, -16'sd21846, 16'sd12345, -16'sd12345, 16'sd256,
                      -16'sd256, 16'sd100, -16'sd100, 16'sd7, -16'sd7, 16'sd32767};
        foreach (fill_vals[i]) send_op(OP_PUSH, fill_vals[i]);
        send_op(OP_PUSH,   16'sd5);        // refused: queue full
        send_op(OP_UNUSED, -16'sd5);       // ignored while full
        send_op(OP_POP,    16'sd0);        // removes the most negative value
        send_op(OP_POP,    16'sd0);
        send_op(OP_CLEAR,  16'sd0);
    endtask

    // random traffic; the push bias swings so the queue visits full and empty
    task automatic test_random_traffic(input int n_items);
        int fill_bias;
        int r;
        fill_bias = 60;
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 5) fill_bias = (fill_bias > 50) ? 30 : 70;
            r = $urandom_range(0, 99);
            if (r < 2)                   send_op(OP_CLEAR, pick_value());
            else if (r < 5)              send_op(OP_UNUSED, pick_value());
            else if (r < 5 + fill_bias)  send_op(OP_PUSH, pick_value());
            else                         send_op(OP_POP, pick_value());
        end
    endtask

    // hold the receiver off while the sender keeps offering, so input stalls
    task automatic test_receiver_stall();
        @(posedge aclk);
        rx_hold_req = 300;
        test_random_traffic(20);
    endtask

    // a long stretch without idling on either side
    task automatic test_no_idle();
        calm = 1'b1;
        test_random_traffic(200);
        calm = 1'b0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_queue();
        test_fill_and_drain();
        test_random_traffic(1000);
        test_receiver_stall();
        test_no_idle();

        @(negedge aclk);
        s_tvalid = 1'b0;
        // drain, then watch a little longer for stray results
        wait (pending_stats.size() == 0);
        repeat (100) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
